### hw/rtl/lbmt_pkg.sv
`default_nettype none

package lbmt_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned PortW    = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CountW   = 13;
  localparam logic [31:0] Golden   = 32'h9e3779b9;
  localparam logic [31:0] SeedC    = 32'hdeadbeef;
  localparam logic [23:0] IpMcPfx  = 24'h01005e;
  localparam logic [CountW-1:0] CountMax = 13'd8191;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_AGE   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_UNICAST = 2'd1,
    ACT_FLOOD   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_MEMBER = 2'd1,
    CFG_MCAST  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             enable;
    logic [MaskW-1:0] member_mask;
    logic [1:0]       mcast_mode;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [PortW-1:0] port;
    logic [MacW-1:0]  dst;
    logic [MacW-1:0]  src;
    logic             bcast;
    logic             mcast;
    logic             own;
    logic             learn_ok;
    logic             ipm;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             fresh;
    logic [PortW-1:0] port;
    logic [MacW-1:0]  mac;
  } entry_t;

  typedef struct packed {
    action_e           action;
    logic              pass_up;
    logic [PortW-1:0]  egress_port;
    logic [MaskW-1:0]  egress_mask;
    logic              learned;
    logic              learn_full;
    logic [CountW-1:0] removed_count;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/lbmt_fifo.sv
`default_nettype none

module lbmt_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slot_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lbmt_hash.sv
`default_nettype none

module lbmt_hash #(
  parameter int unsigned BUCKETS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [lbmt_pkg::MacW-1:0]    src_i,
  input  wire logic [lbmt_pkg::MacW-1:0]    dst_i,
  output logic                              done_o,
  output logic [$clog2(BUCKETS)-1:0]        src_bkt_o,
  output logic [$clog2(BUCKETS)-1:0]        dst_bkt_o
);

  localparam int unsigned BW       = $clog2(BUCKETS);
  localparam int unsigned RedSteps = 33 - BW;
  localparam bit          IsPow2   = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [32:0] DvInit   = 33'(BUCKETS) << (32 - BW);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MIX  = 4'b0010,
    H_RED  = 4'b0100,
    H_DONE = 4'b1000
  } hstate_e;

  // One line of the three-word mix per call.
  function automatic mix_t mix_step(mix_t m, logic [3:0] s);
    mix_t r;
    r = m;
    case (s)
      4'd0: r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
      4'd1: r.b = (m.b - m.c - m.a) ^ (m.a << 8);
      4'd2: r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
      4'd3: r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
      4'd4: r.b = (m.b - m.c - m.a) ^ (m.a << 16);
      4'd5: r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
      4'd6: r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
      4'd7: r.b = (m.b - m.c - m.a) ^ (m.a << 10);
      4'd8: r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
      default: r = m;
    endcase
    return r;
  endfunction

  function automatic mix_t mix_init(logic [lbmt_pkg::MacW-1:0] mac);
    mix_t r;
    r.a = lbmt_pkg::Golden + {mac[23:16], mac[31:24], mac[39:32], mac[47:40]};
    r.b = lbmt_pkg::Golden + {16'd0, mac[7:0], mac[15:8]};
    r.c = lbmt_pkg::SeedC;
    return r;
  endfunction

  hstate_e     state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [5:0]  red_q, red_d;
  logic [32:0] dv_q, dv_d;
  mix_t        m_q [2];
  mix_t        m_d [2];
  mix_t        m_nx [2];
  logic [31:0] r_q [2];
  logic [31:0] r_d [2];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    red_d   = red_q;
    dv_d    = dv_q;
    for (int l = 0; l < 2; l++) begin
      m_nx[l] = mix_step(m_q[l], step_q);
      m_d[l]  = m_q[l];
      r_d[l]  = r_q[l];
    end
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          m_d[0]  = mix_init(src_i);
          m_d[1]  = mix_init(dst_i);
          step_d  = '0;
          state_d = H_MIX;
        end
      end
      H_MIX: begin
        for (int l = 0; l < 2; l++) begin
          m_d[l] = m_nx[l];
        end
        step_d = step_q + 4'd1;
        if (step_q == 4'd8) begin
          for (int l = 0; l < 2; l++) begin
            r_d[l] = m_nx[l].c;
          end
          dv_d    = DvInit;
          red_d   = 6'(RedSteps - 1);
          state_d = IsPow2 ? H_DONE : H_RED;
        end
      end
      H_RED: begin
        // restoring reduction: one conditional subtract per cycle
        for (int l = 0; l < 2; l++) begin
          if ({1'b0, r_q[l]} >= dv_q) begin
            r_d[l] = r_q[l] - dv_q[31:0];
          end
        end
        dv_d  = dv_q >> 1;
        red_d = red_q - 6'd1;
        if (red_q == '0) begin
          state_d = H_DONE;
        end
      end
      H_DONE: state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= '0;
      red_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      red_q   <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
    for (int l = 0; l < 2; l++) begin
      m_q[l] <= m_d[l];
      r_q[l] <= r_d[l];
    end
  end

  assign done_o    = (state_q == H_DONE);
  assign src_bkt_o = r_q[0][BW-1:0];
  assign dst_bkt_o = r_q[1][BW-1:0];

endmodule

`default_nettype wire

### hw/rtl/lbmt_front.sv
`default_nettype none

module lbmt_front #(
  parameter int unsigned BUCKETS = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [lbmt_pkg::PortW-1:0]  port_i,
  input  wire logic [lbmt_pkg::MacW-1:0]   dst_mac_i,
  input  wire logic [lbmt_pkg::MacW-1:0]   src_mac_i,
  input  wire logic                        is_broadcast_i,
  input  wire logic                        is_multicast_i,
  input  wire logic                        dst_is_own_address_i,
  output logic                             cmd_push_o,
  input  wire logic                        cmd_full_i,
  output lbmt_pkg::cmd_t                   cmd_o,
  output logic [$clog2(BUCKETS)-1:0]       src_bkt_o,
  output logic [$clog2(BUCKETS)-1:0]       dst_bkt_o
);

  localparam int unsigned BW = $clog2(BUCKETS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e        state_q, state_d;
  lbmt_pkg::cmd_t cmd_q, cmd_d;
  logic [BW-1:0]  sb_q, db_q;
  logic [BW-1:0]  sb_h, db_h;
  logic           accept, h_done;

  assign full_o = (state_q != F_IDLE);
  assign accept = push_i && !full_o;

  lbmt_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .src_i     (src_mac_i),
    .dst_i     (dst_mac_i),
    .done_o    (h_done),
    .src_bkt_o (sb_h),
    .dst_bkt_o (db_h)
  );

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          // classify the item while the hash runs
          cmd_d.op       = lbmt_pkg::op_e'(op_i);
          cmd_d.port     = port_i;
          cmd_d.dst      = dst_mac_i;
          cmd_d.src      = src_mac_i;
          cmd_d.bcast    = is_broadcast_i;
          cmd_d.mcast    = is_multicast_i;
          cmd_d.own      = dst_is_own_address_i;
          cmd_d.learn_ok = !src_mac_i[40] && (src_mac_i != '0);
          cmd_d.ipm      = (dst_mac_i[47:24] == lbmt_pkg::IpMcPfx);
          state_d        = F_HASH;
        end
      end
      F_HASH: begin
        if (h_done) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!cmd_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (h_done) begin
      sb_q <= sb_h;
      db_q <= db_h;
    end
  end

  assign cmd_push_o = (state_q == F_PUSH);
  assign cmd_o      = cmd_q;
  assign src_bkt_o  = sb_q;
  assign dst_bkt_o  = db_q;

endmodule

`default_nettype wire

### hw/rtl/lbmt_back.sv
`default_nettype none

module lbmt_back #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned PORTS   = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  lbmt_pkg::cfg_t              cfg_i,
  input  wire logic                   cmd_valid_i,
  input  lbmt_pkg::cmd_t              cmd_i,
  input  wire logic [$clog2(BUCKETS)-1:0] src_bkt_i,
  input  wire logic [$clog2(BUCKETS)-1:0] dst_bkt_i,
  output logic                        cmd_pop_o,
  input  wire logic                   res_full_i,
  output logic                        res_push_o,
  output lbmt_pkg::res_t              res_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned CW = lbmt_pkg::CountW;

  typedef enum logic [10:0] {
    S_CLR     = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_SRC_RD  = 11'b000_0000_0100,
    S_SRC_WR  = 11'b000_0000_1000,
    S_DST_RD  = 11'b000_0001_0000,
    S_DST_CHK = 11'b000_0010_0000,
    S_AGE_RD  = 11'b000_0100_0000,
    S_AGE_WR  = 11'b000_1000_0000,
    S_FL_RD   = 11'b001_0000_0000,
    S_FL_WR   = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } bstate_e;

  typedef lbmt_pkg::entry_t [WAYS-1:0] row_t;

  bstate_e        state_q, state_d;
  lbmt_pkg::cmd_t cur_q, cur_d;
  lbmt_pkg::res_t res_q, res_d;
  logic [BW-1:0]  sb_q, sb_d, db_q, db_d;
  logic [BW-1:0]  age_q, age_d, fl_q, fl_d, clr_q, clr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  row_t           mem_q [BUCKETS];
  row_t           rdata_q, wr_row, learn_row, age_row, fl_row;
  logic           rd_en, wr_en;
  logic [BW-1:0]  rd_addr, wr_addr;

  logic [lbmt_pkg::MaskW-1:0] lim, mbits;
  logic [WAYS-1:0] hit, free, sel, dhit, dsel;
  logic [lbmt_pkg::PortW-1:0] dport;
  logic            in_active, dfound, mc_block;
  logic [4:0]      age_n, fl_n;
  logic [CW:0]     fl_sum;

  always_comb begin
    for (int i = 0; i < lbmt_pkg::MaskW; i++) begin
      lim[i] = (i < PORTS);
    end
    mbits     = cfg_i.member_mask & lim;
    in_active = cfg_i.enable && (32'(cmd_i.port) < PORTS) && mbits[cmd_i.port]
                && !cmd_i.own;
  end

  // Row edits and lookup: learn the source, look up the destination, age one bucket, flush one port.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = rdata_q[w].valid && (rdata_q[w].mac == cur_q.src);
      free[w] = !rdata_q[w].valid;
      dhit[w] = rdata_q[w].valid && (rdata_q[w].mac == cur_q.dst);
    end
    sel  = (hit != '0) ? (hit & (~hit + WAYS'(1))) : (free & (~free + WAYS'(1)));
    dsel = dhit & (~dhit + WAYS'(1));
    dfound = (dhit != '0);
    dport  = '0;
    learn_row = rdata_q;
    age_row   = rdata_q;
    fl_row    = rdata_q;
    age_n     = '0;
    fl_n      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (dsel[w]) begin
        dport = dport | rdata_q[w].port;
      end
      if (sel[w]) begin
        learn_row[w] = {1'b1, 1'b1, cur_q.port, cur_q.src};
      end
      if (rdata_q[w].valid) begin
        if (rdata_q[w].fresh) begin
          age_row[w].fresh = 1'b0;
        end else begin
          age_row[w] = '0;
          age_n      = age_n + 5'd1;
        end
      end
      if (rdata_q[w].valid && rdata_q[w].port == cur_q.port) begin
        fl_row[w] = '0;
        fl_n      = fl_n + 5'd1;
      end
    end
    fl_sum   = {1'b0, cnt_q} + (CW+1)'(fl_n);
    mc_block = cur_q.mcast && ((cfg_i.mcast_mode == 2'd3) ||
               (cfg_i.mcast_mode[0] && cur_q.ipm) ||
               (cfg_i.mcast_mode[1] && !cur_q.ipm));
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    res_d      = res_q;
    sb_d       = sb_q;
    db_d       = db_q;
    age_d      = age_q;
    fl_d       = fl_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_row     = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cur_d        = cmd_i;
          sb_d         = src_bkt_i;
          db_d         = dst_bkt_i;
          res_d        = '0;
          res_d.action = lbmt_pkg::ACT_NONE;
          case (cmd_i.op)
            lbmt_pkg::OP_FRAME: begin
              res_d.pass_up = 1'b1;
              if (!in_active) begin
                state_d = S_OUT;
              end else if (cmd_i.learn_ok) begin
                state_d = S_SRC_RD;
              end else begin
                state_d = S_DST_RD;
              end
            end
            lbmt_pkg::OP_AGE: state_d = S_AGE_RD;
            lbmt_pkg::OP_FLUSH: begin
              fl_d    = '0;
              cnt_d   = '0;
              state_d = S_FL_RD;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SRC_RD: begin
        rd_en   = 1'b1;
        rd_addr = sb_q;
        state_d = S_SRC_WR;
      end
      S_SRC_WR: begin
        if (sel != '0) begin
          wr_en         = 1'b1;
          wr_addr       = sb_q;
          wr_row        = learn_row;
          res_d.learned = 1'b1;
        end else begin
          res_d.learn_full = 1'b1;
        end
        state_d = S_DST_RD;
      end
      S_DST_RD: begin
        rd_en   = 1'b1;
        rd_addr = db_q;
        state_d = S_DST_CHK;
      end
      S_DST_CHK: begin
        if (!cur_q.bcast && !cur_q.mcast && dfound && dport == cur_q.port) begin
          res_d.action  = lbmt_pkg::ACT_DROP;
          res_d.pass_up = 1'b0;
        end else if (mc_block) begin
          res_d.action = lbmt_pkg::ACT_NONE;
        end else if (cur_q.bcast || cur_q.mcast || !dfound) begin
          res_d.action      = lbmt_pkg::ACT_FLOOD;
          res_d.egress_mask = mbits & ~(lbmt_pkg::MaskW'(1) << cur_q.port);
        end else begin
          res_d.action      = lbmt_pkg::ACT_UNICAST;
          res_d.pass_up     = 1'b0;
          res_d.egress_port = dport;
        end
        state_d = S_OUT;
      end
      S_AGE_RD: begin
        rd_en   = 1'b1;
        rd_addr = age_q;
        state_d = S_AGE_WR;
      end
      S_AGE_WR: begin
        wr_en               = 1'b1;
        wr_addr             = age_q;
        wr_row              = age_row;
        res_d.removed_count = CW'(age_n);
        age_d   = (age_q == BW'(BUCKETS - 1)) ? '0 : age_q + BW'(1);
        state_d = S_OUT;
      end
      S_FL_RD: begin
        rd_en   = 1'b1;
        rd_addr = fl_q;
        state_d = S_FL_WR;
      end
      S_FL_WR: begin
        wr_en   = 1'b1;
        wr_addr = fl_q;
        wr_row  = fl_row;
        cnt_d   = (fl_sum > (CW+1)'(lbmt_pkg::CountMax)) ? lbmt_pkg::CountMax
                                                          : fl_sum[CW-1:0];
        if (fl_q == BW'(BUCKETS - 1)) begin
          res_d.removed_count = cnt_d;
          state_d             = S_OUT;
        end else begin
          fl_d    = fl_q + BW'(1);
          state_d = S_FL_RD;
        end
      end
      S_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      age_q   <= '0;
      fl_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      age_q   <= age_d;
      fl_q    <= fl_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    sb_q  <= sb_d;
    db_q  <= db_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign res_o = res_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE)
    else $error("command taken outside idle");

  a_learn_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !(res_o.learned && res_o.learn_full))
    else $error("learned and learn_full both set");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q != S_CLR) |-> $past(rd_en))
    else $error("row written without a preceding read");

  a_mask_flood: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.action != lbmt_pkg::ACT_FLOOD) |-> res_o.egress_mask == '0)
    else $error("egress mask set on a non-flood result");

endmodule

`default_nettype wire

### hw/rtl/learning_bridge_mac_table.sv
`default_nettype none
// Channel   Handshake                        Payload
// input     push / full (transfer: push&!full) op, port, dst_mac, src_mac, flags
// result    empty / pop (transfer: pop&!empty) action .. removed_count
// config    cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// A frame passes the front through the nine-line hash mixer (plus
// 33-clog2(BUCKETS) reduction steps when BUCKETS is not a power of two); the
// back then reads the source bucket and writes it back when it learns the
// source, then reads the destination bucket (it goes straight to the result
// when the bridge is off for the frame). An age tick reads and writes one
// bucket; a port flush does one row read and one row write per bucket.
// After reset a clearing pass over every bucket empties the table; items wait
// in the queues meanwhile, configuration writes are taken as ever.
// Front and back stall on their own through the command queue; the result
// queue holds two results.

module learning_bridge_mac_table #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned PORTS   = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op_i,
  input  wire logic [2:0]  port_i,
  input  wire logic [47:0] dst_mac_i,
  input  wire logic [47:0] src_mac_i,
  input  wire logic        is_broadcast_i,
  input  wire logic        is_multicast_i,
  input  wire logic        dst_is_own_address_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       action_o,
  output logic             pass_up_o,
  output logic [2:0]       egress_port_o,
  output logic [7:0]       egress_mask_o,
  output logic             learned_o,
  output logic             learn_full_o,
  output logic [12:0]      removed_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned CmdW = $bits(lbmt_pkg::cmd_t) + 2 * BW;
  localparam int unsigned ResW = $bits(lbmt_pkg::res_t);

  lbmt_pkg::cfg_t cfg_q, cfg_d;

  // Configuration registers: always ready, index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (lbmt_pkg::cfg_idx_e'(cfg_index_i))
        lbmt_pkg::CFG_ENABLE: cfg_d.enable      = cfg_data_i[0];
        lbmt_pkg::CFG_MEMBER: cfg_d.member_mask = cfg_data_i;
        lbmt_pkg::CFG_MCAST:  cfg_d.mcast_mode  = cfg_data_i[1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take items, classify them and hash both addresses.
  logic           f_push, c_full, c_empty, c_pop;
  lbmt_pkg::cmd_t f_cmd, b_cmd;
  logic [BW-1:0]  f_sb, f_db, b_sb, b_db;
  logic [CmdW-1:0] c_out;

  lbmt_front #(.BUCKETS(BUCKETS)) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push_i               (push),
    .full_o               (full),
    .op_i                 (op_i),
    .port_i               (port_i),
    .dst_mac_i            (dst_mac_i),
    .src_mac_i            (src_mac_i),
    .is_broadcast_i       (is_broadcast_i),
    .is_multicast_i       (is_multicast_i),
    .dst_is_own_address_i (dst_is_own_address_i),
    .cmd_push_o           (f_push),
    .cmd_full_i           (c_full),
    .cmd_o                (f_cmd),
    .src_bkt_o            (f_sb),
    .dst_bkt_o            (f_db)
  );

  // Command queue decouples hashing from the table walk.
  lbmt_fifo #(.W(CmdW), .DEPTH(2)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .full_o  (c_full),
    .data_i  ({f_cmd, f_sb, f_db}),
    .pop_i   (c_pop),
    .empty_o (c_empty),
    .data_o  (c_out)
  );

  assign {b_cmd, b_sb, b_db} = c_out;

  // Back: bucket memory, learning, lookup, ageing and flush.
  logic           r_push, r_full;
  lbmt_pkg::res_t b_res, o_res;
  logic [ResW-1:0] r_out;

  lbmt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .PORTS(PORTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!c_empty),
    .cmd_i       (b_cmd),
    .src_bkt_i   (b_sb),
    .dst_bkt_i   (b_db),
    .cmd_pop_o   (c_pop),
    .res_full_i  (r_full),
    .res_push_o  (r_push),
    .res_o       (b_res)
  );

  // Result queue: the oldest result sits on the ports while empty is low.
  lbmt_fifo #(.W(ResW), .DEPTH(2)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .full_o  (r_full),
    .data_i  (b_res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (r_out)
  );

  assign o_res           = lbmt_pkg::res_t'(r_out);
  assign action_o        = o_res.action;
  assign pass_up_o       = o_res.pass_up;
  assign egress_port_o   = o_res.egress_port;
  assign egress_mask_o   = o_res.egress_mask;
  assign learned_o       = o_res.learned;
  assign learn_full_o    = o_res.learn_full;
  assign removed_count_o = o_res.removed_count;

endmodule

`default_nettype wire
